[rtl/core/afsk_tsg_pkg.sv]
// ----------------------------------------------------------------------------
// afsk_tsg_pkg
// Shared types and constants of the AFSK tone sample generator.
// ----------------------------------------------------------------------------
`default_nettype none

package afsk_tsg_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int STEP_BITS      = 32;
    localparam int GAIN_BITS      = 16;
    localparam int COUNT_BITS     = 16;
    localparam int SAMPLE_BITS    = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_START_STEP  = 3'd0,
        CFG_BIT0_STEP   = 3'd1,
        CFG_BIT1_STEP   = 3'd2,
        CFG_END_STEP    = 3'd3,
        CFG_VOLUME_GAIN = 3'd4,
        CFG_SAMPLES     = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        SYM_START = 2'd0,
        SYM_BIT0  = 2'd1,
        SYM_BIT1  = 2'd2,
        SYM_END   = 2'd3
    } t_symbol;

    localparam logic [GAIN_BITS-1:0]  FULL_GAIN     = 16'd32768;
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET    = 16'd32768;
    localparam logic [COUNT_BITS-1:0] SAMPLES_RESET = 16'd480;

    // pi/2 in Q62 and the Taylor series divisors (2n)(2n+1), n = 1..13
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
    localparam int          SERIES_TERMS = 13;
    localparam logic [63:0] SERIES_DIV [1:SERIES_TERMS] = '{
        64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
    };

endpackage

`default_nettype wire

[rtl/core/afsk_tone_sample_generator.sv]
// ----------------------------------------------------------------------------
// afsk_tone_sample_generator
// One signed sine sample per symbol tick, phase restarted at each tone start.
// ----------------------------------------------------------------------------
// Each accepted tick returns one sample after two register stages: the sine
// ROM read (address taken from the phase accumulator, ROM output registered)
// and the Q15 volume multiply into the output register. A new tick is taken
// every cycle; the input stalls only while both stages hold a word and the
// output is stalled. One 15x16 multiplier does the scaling. The sine ROM is
// built at elaboration from SINE_TABLE_DEPTH (a power of two) and needs no
// clearing after reset. The configuration port is always ready; write it only
// while the block is idle.
`default_nettype none

module afsk_tone_sample_generator #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    // configuration write channel
    input  wire logic                                      i_cfg_valid,
    output logic                                           o_cfg_ready,
    input  wire logic [afsk_tsg_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire logic [afsk_tsg_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    // tick input
    input  wire logic                                      i_in_valid,
    output logic                                           o_in_stall,
    input  wire logic [1:0]                                i_symbol_code,
    // sample output
    output logic                                           o_out_valid,
    input  wire logic                                      i_out_stall,
    output logic signed [afsk_tsg_pkg::SAMPLE_BITS-1:0]    o_sample_value,
    output logic                                           o_last_of_tone
);

    localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int HALF      = SINE_TABLE_DEPTH / 2;
    localparam int QUARTER   = SINE_TABLE_DEPTH / 4;
    localparam logic [63:0] QUARTER_W = 64'(QUARTER);
    localparam logic [63:0] HALF_W    = 64'(HALF);

    typedef logic signed [afsk_tsg_pkg::SAMPLE_BITS-1:0] t_sine_rom [SINE_TABLE_DEPTH];

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    function automatic logic [15:0] quarter_sine(input logic [63:0] q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rnd;
        x = (afsk_tsg_pkg::HALF_PI_Q62 / QUARTER_W) * q
            + ((afsk_tsg_pkg::HALF_PI_Q62 % QUARTER_W) * q) / QUARTER_W;
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= afsk_tsg_pkg::SERIES_TERMS; n++) begin
            term = mul_q62(term, x2) / afsk_tsg_pkg::SERIES_DIV[n];
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        rnd = (((sum >> 20) * 64'd32767) + (64'd1 << 41)) >> 42;
        return rnd[15:0];
    endfunction

    function automatic t_sine_rom build_rom();
        t_sine_rom   rom;
        logic [63:0] r;
        logic [63:0] q;
        logic [15:0] v;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            r = 64'(k) % HALF_W;
            q = (r <= QUARTER_W) ? r : HALF_W - r;
            v = quarter_sine(q);
            rom[k] = (k >= HALF) ? -v : v;
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_rom();

    // configuration registers
    logic [afsk_tsg_pkg::STEP_BITS-1:0]  r_start_step;
    logic [afsk_tsg_pkg::STEP_BITS-1:0]  r_bit0_step;
    logic [afsk_tsg_pkg::STEP_BITS-1:0]  r_bit1_step;
    logic [afsk_tsg_pkg::STEP_BITS-1:0]  r_end_step;
    logic [afsk_tsg_pkg::GAIN_BITS-1:0]  r_volume_gain;
    logic [afsk_tsg_pkg::COUNT_BITS-1:0] r_samples_per_tone;

    // tone state
    logic [PHASE_BITS-1:0]               r_phase;
    logic [afsk_tsg_pkg::COUNT_BITS-1:0] r_sample_index;
    logic [PHASE_BITS-1:0]               n_phase;
    logic [afsk_tsg_pkg::COUNT_BITS-1:0] n_sample_index;

    // pipeline
    logic                                        r_s1_valid;
    logic signed [afsk_tsg_pkg::SAMPLE_BITS-1:0] r_s1_sine;
    logic                                        r_s1_last;
    logic                                        r_out_valid;
    logic signed [afsk_tsg_pkg::SAMPLE_BITS-1:0] r_out_sample;
    logic                                        r_out_last;

    logic                                    en_out;
    logic                                    en_s1;
    logic                                    in_accept;
    logic [afsk_tsg_pkg::STEP_BITS-1:0]      step;
    logic [PHASE_BITS-1:0]                   phase_cur;
    logic [ADDR_BITS-1:0]                    rom_addr;
    logic [afsk_tsg_pkg::COUNT_BITS:0]       count;
    logic                                    n_last;
    logic [afsk_tsg_pkg::GAIN_BITS-1:0]      gain;
    logic [afsk_tsg_pkg::SAMPLE_BITS-2:0]    sine_abs;
    logic [afsk_tsg_pkg::SAMPLE_BITS+afsk_tsg_pkg::GAIN_BITS-2:0] product;
    logic [afsk_tsg_pkg::SAMPLE_BITS-1:0]    mag;
    logic signed [afsk_tsg_pkg::SAMPLE_BITS-1:0] n_out_sample;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_step       <= '0;
            r_bit0_step        <= '0;
            r_bit1_step        <= '0;
            r_end_step         <= '0;
            r_volume_gain      <= afsk_tsg_pkg::GAIN_RESET;
            r_samples_per_tone <= afsk_tsg_pkg::SAMPLES_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                afsk_tsg_pkg::CFG_START_STEP:  r_start_step  <= i_cfg_data;
                afsk_tsg_pkg::CFG_BIT0_STEP:   r_bit0_step   <= i_cfg_data;
                afsk_tsg_pkg::CFG_BIT1_STEP:   r_bit1_step   <= i_cfg_data;
                afsk_tsg_pkg::CFG_END_STEP:    r_end_step    <= i_cfg_data;
                afsk_tsg_pkg::CFG_VOLUME_GAIN: r_volume_gain <= i_cfg_data[15:0];
                afsk_tsg_pkg::CFG_SAMPLES:     r_samples_per_tone <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // each stage advances when its successor is empty or moving
    assign en_out     = !r_out_valid || !i_out_stall;
    assign en_s1      = !r_s1_valid || en_out;
    assign o_in_stall = !en_s1;
    assign in_accept  = i_in_valid && en_s1;

    always_comb begin
        case (i_symbol_code)
            afsk_tsg_pkg::SYM_START: step = r_start_step;
            afsk_tsg_pkg::SYM_BIT0:  step = r_bit0_step;
            afsk_tsg_pkg::SYM_BIT1:  step = r_bit1_step;
            default:                 step = r_end_step;
        endcase
    end

    // restart the phase on the first sample of a tone
    assign phase_cur      = (r_sample_index == '0) ? '0 : r_phase;
    assign rom_addr       = phase_cur[PHASE_BITS-1 -: ADDR_BITS];
    assign n_phase        = phase_cur + PHASE_BITS'(step);
    assign count          = {1'b0, r_sample_index} + 17'd1;
    assign n_last         = count >= {1'b0, r_samples_per_tone};
    assign n_sample_index = n_last ? '0 : count[afsk_tsg_pkg::COUNT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= '0;
            r_sample_index <= '0;
            r_s1_valid     <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase        <= n_phase;
                r_sample_index <= n_sample_index;
            end
            if (en_s1) begin
                r_s1_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_sine <= SINE_ROM[rom_addr];
            r_s1_last <= n_last;
        end
    end

    // scale the magnitude and truncate toward zero
    assign gain     = (r_volume_gain > afsk_tsg_pkg::FULL_GAIN) ? afsk_tsg_pkg::FULL_GAIN
                                                                : r_volume_gain;
    assign sine_abs = r_s1_sine[15] ? 15'(-r_s1_sine) : r_s1_sine[14:0];
    assign product  = sine_abs * gain;
    assign mag      = product[30:15];
    assign n_out_sample = r_s1_sine[15] ? -$signed(mag) : $signed(mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s1_valid) begin
            r_out_sample <= n_out_sample;
            r_out_last   <= r_s1_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_sample;
    assign o_last_of_tone = r_out_last;

    // both stages full and output held: the input must stall
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while pipeline full and stalled");

    // a tone ends by clearing the sample position
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_last) |=> (r_sample_index == '0))
        else $error("sample position not cleared after last sample");

    // gain never exceeds full scale, so the negative limit is never reached
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_sample != 16'sh8000))
        else $error("sample reached negative full scale");

endmodule

`default_nettype wire

[sim/afsk_tsg_checker.sv]
// ----------------------------------------------------------------------------
// afsk_tsg_checker
// Watches the tick, sample and register channels of the tone sample generator,
// predicts every sample from its own copy of the tone state, and compares.
// ----------------------------------------------------------------------------
module afsk_tsg_checker #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_valid,
    input  wire logic                                    i_cfg_ready,
    input  wire logic [afsk_tsg_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [afsk_tsg_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                                    i_in_valid,
    input  wire logic                                    i_in_stall,
    input  wire logic [1:0]                              i_symbol_code,
    input  wire logic                                    i_out_valid,
    input  wire logic                                    i_out_stall,
    input  wire logic [afsk_tsg_pkg::SAMPLE_BITS-1:0]    i_sample_value,
    input  wire logic                                    i_last_of_tone,
    output int                                           o_mismatches,
    output int                                           o_pending,
    output int                                           o_samples,
    output int                                           o_tone_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int ROM_SHIFT = PHASE_BITS - ADDR_BITS;

    typedef struct packed {
        logic signed [afsk_tsg_pkg::SAMPLE_BITS-1:0] value;
        logic                                        last;
    } t_tone_sample;

    logic signed [afsk_tsg_pkg::SAMPLE_BITS-1:0] sine_rom [SINE_TABLE_DEPTH];

    // register copies, indexed by symbol for the steps
    logic [afsk_tsg_pkg::STEP_BITS-1:0]  step_of_symbol [4];
    logic [afsk_tsg_pkg::GAIN_BITS-1:0]  gain_q15;
    logic [afsk_tsg_pkg::COUNT_BITS-1:0] tone_len;

    logic [PHASE_BITS-1:0]               phase_acc;
    logic [afsk_tsg_pkg::COUNT_BITS-1:0] tone_pos;

    t_tone_sample expected_samples [$];

    // floor(a * b / 2^62), low 64 bits
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // quarter wave by odd Taylor series in Q62, mirrored to the full wave
    initial begin : build_sine_rom
        longint unsigned half_n, quarter_n, q, x, x2, term, sum;
        int mag_i;
        half_n    = SINE_TABLE_DEPTH / 2;
        quarter_n = SINE_TABLE_DEPTH / 4;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            q = k % half_n;
            if (q > quarter_n) begin
                q = half_n - q;
            end
            x = (afsk_tsg_pkg::HALF_PI_Q62 / quarter_n) * q
                + ((afsk_tsg_pkg::HALF_PI_Q62 % quarter_n) * q) / quarter_n;
            x2   = q62_mul(x, x);
            term = x;
            sum  = x;
            for (int n = 1; n <= afsk_tsg_pkg::SERIES_TERMS; n++) begin
                term = q62_mul(term, x2) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            mag_i = int'((((sum >> 20) * 64'd32767) + (64'd1 << 41)) >> 42);
            sine_rom[k] = 16'((k >= half_n) ? -mag_i : mag_i);
        end
    end

    // advance the tone state by one tick and return the sample it yields
    function automatic t_tone_sample next_tone_sample(input afsk_tsg_pkg::t_symbol sym);
        t_tone_sample                      res;
        logic [PHASE_BITS-1:0]             step;
        int                                rom_val;
        int unsigned                       mag;
        int unsigned                       gain_eff;
        logic [afsk_tsg_pkg::COUNT_BITS:0] count;
        step = PHASE_BITS'(step_of_symbol[sym]);
        // restart phase on the first sample of a tone
        if (tone_pos == '0) begin
            phase_acc = '0;
        end
        rom_val  = sine_rom[phase_acc >> ROM_SHIFT];
        gain_eff = 32'((gain_q15 > afsk_tsg_pkg::FULL_GAIN) ? afsk_tsg_pkg::FULL_GAIN
                                                            : gain_q15);
        mag      = (rom_val < 0) ? -rom_val : rom_val;
        mag      = (mag * gain_eff) >> 15;
        res.value = 16'((rom_val < 0) ? -mag : mag);
        phase_acc = phase_acc + step;
        count     = tone_pos + 1'b1;
        res.last  = (count >= tone_len);
        tone_pos  = res.last ? '0 : count[afsk_tsg_pkg::COUNT_BITS-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        $display("%0t ns  %s: expected %0d, got %0d", $time, what, want_v, got_v);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_tone_sample got, want;
        if (!i_rst_n) begin
            foreach (step_of_symbol[s]) begin
                step_of_symbol[s] = '0;
            end
            gain_q15  = afsk_tsg_pkg::GAIN_RESET;
            tone_len  = afsk_tsg_pkg::SAMPLES_RESET;
            phase_acc = '0;
            tone_pos  = '0;
            expected_samples.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_samples.push_back(
                    next_tone_sample(afsk_tsg_pkg::t_symbol'(i_symbol_code)));
            end
            if (i_out_valid && !i_out_stall) begin
                got.value = i_sample_value;
                got.last  = i_last_of_tone;
                o_samples++;
                if (got.last) begin
                    o_tone_ends++;
                end
                if (expected_samples.size() == 0) begin
                    report_mismatch("sample word with nothing pending", 0, got.value);
                end else begin
                    want = expected_samples.pop_front();
                    if (got.value !== want.value) begin
                        report_mismatch("sample_value", want.value, got.value);
                    end
                    if (got.last !== want.last) begin
                        report_mismatch("last_of_tone", want.last, got.last);
                    end
                end
            end
            // a write takes effect from the next tick on
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    afsk_tsg_pkg::CFG_START_STEP:
                        step_of_symbol[afsk_tsg_pkg::SYM_START] = i_cfg_data;
                    afsk_tsg_pkg::CFG_BIT0_STEP:
                        step_of_symbol[afsk_tsg_pkg::SYM_BIT0] = i_cfg_data;
                    afsk_tsg_pkg::CFG_BIT1_STEP:
                        step_of_symbol[afsk_tsg_pkg::SYM_BIT1] = i_cfg_data;
                    afsk_tsg_pkg::CFG_END_STEP:
                        step_of_symbol[afsk_tsg_pkg::SYM_END] = i_cfg_data;
                    afsk_tsg_pkg::CFG_VOLUME_GAIN:
                        gain_q15 = i_cfg_data[afsk_tsg_pkg::GAIN_BITS-1:0];
                    afsk_tsg_pkg::CFG_SAMPLES:
                        tone_len = i_cfg_data[afsk_tsg_pkg::COUNT_BITS-1:0];
                    default: ;  // drop writes to unused indexes
                endcase
            end
        end
        o_pending <= expected_samples.size();
    end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the AFSK tone sample generator: a short directed run over the
// register extremes and tone corner cases, then random phases of framed tone
// sequences under random input gaps and output stalls. The checker beside the
// block predicts and compares every sample word.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int RANDOM_TICKS     = 1100;
    localparam int IDLE_LIMIT       = 2000;

    // indexes past the last register, expected to be ignored
    localparam logic [afsk_tsg_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [afsk_tsg_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_HI = 3'd7;

    logic                                        i_clk;
    logic                                        i_rst_n;
    logic                                        i_cfg_valid;
    logic                                        o_cfg_ready;
    logic [afsk_tsg_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index;
    logic [afsk_tsg_pkg::CFG_DATA_BITS-1:0]      i_cfg_data;
    logic                                        i_in_valid;
    logic                                        o_in_stall;
    logic [1:0]                                  i_symbol_code;
    logic                                        o_out_valid;
    logic                                        i_out_stall;
    logic signed [afsk_tsg_pkg::SAMPLE_BITS-1:0] o_sample_value;
    logic                                        o_last_of_tone;

    int mismatches;
    int pending;
    int samples_seen;
    int tone_ends;

    int tx_gap_pct;
    int rx_stall_pct;
    int stall_left;
    int tone_len;
    int ticks_sent;
    int tick_stop;
    int cfg_writes;
    int phases;
    int idle_cycles;

    afsk_tone_sample_generator #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_symbol_code  (i_symbol_code),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_value (o_sample_value),
        .o_last_of_tone (o_last_of_tone)
    );

    afsk_tsg_checker #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) sample_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_symbol_code  (i_symbol_code),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_sample_value (o_sample_value),
        .i_last_of_tone (o_last_of_tone),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_samples      (samples_seen),
        .o_tone_ends    (tone_ends)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) != 0) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'h4000_0000;
            3: return $urandom_range(1, 32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    // upper half random: only the low 16 bits reach the gain register
    function automatic logic [31:0] pick_gain();
        logic [15:0] lo;
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(5))
                    0: lo = 16'd0;
                    1: lo = 16'd1;
                    2: lo = 16'd32767;
                    3: lo = 16'd32768;
                    4: lo = 16'd32769;
                    default: lo = 16'hFFFF;
                endcase
            end
            1: lo = 16'($urandom);
            default: lo = 16'($urandom_range(32768));
        endcase
        return {16'($urandom), lo};
    endfunction

    // keep tones short so that frames complete within a phase
    function automatic logic [31:0] pick_len();
        int r;
        logic [15:0] lo;
        r = $urandom_range(19);
        if (r < 14) begin
            lo = 16'($urandom_range(1, 8));
        end else if (r < 16) begin
            lo = 16'd0;
        end else if (r < 18) begin
            lo = 16'($urandom_range(9, 40));
        end else if (r == 18) begin
            lo = 16'd480;
        end else begin
            lo = 16'hFFFF;
        end
        return {16'($urandom), lo};
    endfunction

    task automatic write_reg(input logic [afsk_tsg_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        if (idx == afsk_tsg_pkg::CFG_SAMPLES) begin
            tone_len = int'(data[15:0]);
        end
        cfg_writes++;
    endtask

    task automatic send_symbol(input afsk_tsg_pkg::t_symbol sym);
        int gap;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_symbol_code <= sym;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    // hold the sender until every pending sample word has come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // one tone, with the odd symbol swapped mid-tone
    task automatic send_tone(input afsk_tsg_pkg::t_symbol sym);
        int n;
        n = (tone_len == 0) ? 1 : tone_len;
        for (int i = 0; i < n && ticks_sent < tick_stop; i++) begin
            if ($urandom_range(19) == 0) begin
                send_symbol(afsk_tsg_pkg::t_symbol'($urandom_range(3)));
            end else begin
                send_symbol(sym);
            end
        end
    endtask

    initial begin
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else begin
                stall_left = pick_gap(rx_stall_pct);
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                    $display("afsk_tone_sample_generator: mismatch");
                    $finish;
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = afsk_tsg_pkg::CFG_START_STEP;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_symbol_code = afsk_tsg_pkg::SYM_START;
        tx_gap_pct    = 0;
        rx_stall_pct  = 0;
        tone_len      = int'(afsk_tsg_pkg::SAMPLES_RESET);
        ticks_sent    = 0;
        tick_stop     = 0;
        cfg_writes    = 0;
        phases        = 0;
        idle_cycles   = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: all steps zero
        send_symbol(afsk_tsg_pkg::SYM_START);
        send_symbol(afsk_tsg_pkg::SYM_END);
        wait_idle();

        // gain above full scale saturates, symbols switch mid-tone
        write_reg(afsk_tsg_pkg::CFG_START_STEP, 32'h0100_0000);
        write_reg(afsk_tsg_pkg::CFG_BIT0_STEP, 32'hFFFF_FFFF);
        write_reg(afsk_tsg_pkg::CFG_BIT1_STEP, 32'h4000_0000);
        write_reg(afsk_tsg_pkg::CFG_END_STEP, 32'h8000_0000);
        write_reg(afsk_tsg_pkg::CFG_VOLUME_GAIN, 32'h0000_FFFF);
        write_reg(afsk_tsg_pkg::CFG_SAMPLES, 32'd6);
        send_symbol(afsk_tsg_pkg::SYM_START);
        send_symbol(afsk_tsg_pkg::SYM_START);
        send_symbol(afsk_tsg_pkg::SYM_BIT0);
        send_symbol(afsk_tsg_pkg::SYM_BIT1);
        send_symbol(afsk_tsg_pkg::SYM_END);
        send_symbol(afsk_tsg_pkg::SYM_START);
        wait_idle();

        // zero length: every sample ends its tone
        write_reg(afsk_tsg_pkg::CFG_SAMPLES, 32'hFFFF_0000);
        write_reg(afsk_tsg_pkg::CFG_VOLUME_GAIN, 32'hABCD_7FFF);
        send_symbol(afsk_tsg_pkg::SYM_BIT1);
        send_symbol(afsk_tsg_pkg::SYM_END);
        send_symbol(afsk_tsg_pkg::SYM_BIT0);
        wait_idle();

        // longest tone, then the length drops below the position
        write_reg(afsk_tsg_pkg::CFG_SAMPLES, 32'h0000_FFFF);
        write_reg(afsk_tsg_pkg::CFG_VOLUME_GAIN, 32'd32768);
        send_symbol(afsk_tsg_pkg::SYM_BIT1);
        send_symbol(afsk_tsg_pkg::SYM_BIT1);
        send_symbol(afsk_tsg_pkg::SYM_BIT1);
        wait_idle();
        write_reg(afsk_tsg_pkg::CFG_SAMPLES, 32'd2);
        write_reg(afsk_tsg_pkg::CFG_VOLUME_GAIN, 32'd32769);
        write_reg(CFG_UNUSED_LO, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED_HI, 32'hFFFF_FFFF);
        send_symbol(afsk_tsg_pkg::SYM_BIT1);
        send_symbol(afsk_tsg_pkg::SYM_BIT1);
        wait_idle();

        write_reg(afsk_tsg_pkg::CFG_VOLUME_GAIN, 32'd0);
        send_symbol(afsk_tsg_pkg::SYM_START);
        send_symbol(afsk_tsg_pkg::SYM_END);
        wait_idle();
        write_reg(afsk_tsg_pkg::CFG_VOLUME_GAIN, 32'd1);
        send_symbol(afsk_tsg_pkg::SYM_BIT1);
        send_symbol(afsk_tsg_pkg::SYM_BIT1);

        tick_stop = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < tick_stop) begin
            wait_idle();
            phases++;
            tx_gap_pct   = pick_pct();
            rx_stall_pct = pick_pct();
            if (phases == 1 || $urandom_range(1))
                write_reg(afsk_tsg_pkg::CFG_START_STEP, pick_step());
            if (phases == 1 || $urandom_range(1))
                write_reg(afsk_tsg_pkg::CFG_BIT0_STEP, pick_step());
            if (phases == 1 || $urandom_range(1))
                write_reg(afsk_tsg_pkg::CFG_BIT1_STEP, pick_step());
            if (phases == 1 || $urandom_range(1))
                write_reg(afsk_tsg_pkg::CFG_END_STEP, pick_step());
            if (phases == 1 || $urandom_range(1))
                write_reg(afsk_tsg_pkg::CFG_VOLUME_GAIN, pick_gain());
            if (phases == 1 || $urandom_range(1))
                write_reg(afsk_tsg_pkg::CFG_SAMPLES, pick_len());
            if ($urandom_range(4) == 0) begin
                write_reg($urandom_range(1) ? CFG_UNUSED_LO : CFG_UNUSED_HI, $urandom);
            end
            // framed message: start tone, a few bit tones, end tone
            while (ticks_sent < tick_stop) begin
                send_tone(afsk_tsg_pkg::SYM_START);
                repeat ($urandom_range(1, 6)) begin
                    send_tone($urandom_range(1) ? afsk_tsg_pkg::SYM_BIT1
                                                : afsk_tsg_pkg::SYM_BIT0);
                end
                send_tone(afsk_tsg_pkg::SYM_END);
                if ($urandom_range(2) == 0) break;
            end
        end

        wait_idle();
        repeat (8) @(negedge i_clk);

        $display("covered %0d ticks in %0d random phases, %0d register writes",
                 ticks_sent, phases, cfg_writes);
        $display("checked %0d sample words, %0d of them closing a tone",
                 samples_seen, tone_ends);
        if (mismatches == 0 && pending == 0) begin
            $display("afsk_tone_sample_generator: match");
        end else begin
            $display("afsk_tone_sample_generator: mismatch");
        end
        $finish;
    end

endmodule
